[rtl/wsdf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package wsdf_pkg;

    // Default width of the payload length counter.
    localparam int LENGTH_BITS = 32;

    // Header field masks and the special length codes.
    localparam logic [7:0] OPCODE_MASK = 8'h0F;
    localparam logic [7:0] MASK_FLAG   = 8'h80;
    localparam logic [7:0] LEN7_MASK   = 8'h7F;
    localparam logic [6:0] LEN_EXT16   = 7'd126;
    localparam logic [6:0] LEN_EXT64   = 7'd127;

    // Extension and key byte counts, less one where the count is compared before increment.
    localparam logic [2:0] EXT16_LAST = 3'd1;
    localparam logic [2:0] EXT64_LAST = 3'd7;
    localparam logic [2:0] KEY_LAST   = 3'd3;

    // Stream widths.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    // One result beat from the parser to the output register.
    typedef struct packed {
        logic [7:0] payload_byte;
        logic [3:0] frame_opcode;
        logic       last_byte;
        logic       empty_frame;
    } t_result;

endpackage

`default_nettype wire

[rtl/wsdf_in_reg.sv]
`timescale 1ns / 1ps
`default_nettype none

module wsdf_in_reg (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_advance,
    output logic            o_valid,
    output logic [7:0]      o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    // The register takes a new beat when empty or when its beat moves on.
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

`default_nettype wire

[rtl/wsdf_parser.sv]
`timescale 1ns / 1ps
`default_nettype none

module wsdf_parser #(
    parameter int LB = wsdf_pkg::LENGTH_BITS
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_advance,
    output logic            o_res_valid,
    output wsdf_pkg::t_result o_res
);

    typedef enum logic [2:0] {
        PH_HDR0  = 3'd0,
        PH_HDR1  = 3'd1,
        PH_EXT16 = 3'd2,
        PH_EXT64 = 3'd3,
        PH_KEY   = 3'd4,
        PH_DATA  = 3'd5
    } t_phase;

    t_phase        r_phase, n_phase;
    logic [2:0]    r_hcount, n_hcount;
    logic [LB-1:0] r_len, n_len;
    logic          r_mask_en, n_mask_en;
    logic [31:0]   r_key, n_key;
    logic [1:0]    r_midx, n_midx;
    logic [3:0]    r_opcode, n_opcode;

    logic       consume;
    logic       len_complete;
    logic       hdr_complete;
    logic [7:0] key_byte;

    assign consume  = i_valid && i_advance;
    // Key byte 0 sits in the top byte of the key register.
    assign key_byte = r_key[{~r_midx, 3'b000} +: 8];

    // Next state and result for the byte at the head of the input register.
    always_comb begin
        n_phase      = r_phase;
        n_hcount     = r_hcount;
        n_len        = r_len;
        n_mask_en    = r_mask_en;
        n_key        = r_key;
        n_midx       = r_midx;
        n_opcode     = r_opcode;
        len_complete = 1'b0;
        hdr_complete = 1'b0;
        o_res_valid  = 1'b0;
        o_res        = '0;

        if (consume) begin
            case (r_phase)
                PH_HDR1: begin
                    n_mask_en = (i_byte & wsdf_pkg::MASK_FLAG) != 8'd0;
                    n_hcount  = 3'd0;
                    n_len     = '0;
                    if (i_byte[6:0] == wsdf_pkg::LEN_EXT16) begin
                        n_phase = PH_EXT16;
                    end else if (i_byte[6:0] == wsdf_pkg::LEN_EXT64) begin
                        n_phase = PH_EXT64;
                    end else begin
                        n_len        = {{(LB-7){1'b0}}, i_byte[6:0]};
                        len_complete = 1'b1;
                    end
                end
                PH_EXT16: begin
                    n_len    = {r_len[LB-9:0], i_byte};
                    n_hcount = r_hcount + 3'd1;
                    if (r_hcount == wsdf_pkg::EXT16_LAST) begin
                        len_complete = 1'b1;
                    end
                end
                PH_EXT64: begin
                    // Bytes above the counter width fall off the top.
                    n_len = {r_len[LB-9:0], i_byte};
                    if (r_hcount == wsdf_pkg::EXT64_LAST) begin
                        len_complete = 1'b1;
                    end else begin
                        n_hcount = r_hcount + 3'd1;
                    end
                end
                PH_KEY: begin
                    n_key    = {r_key[23:0], i_byte};
                    n_hcount = r_hcount + 3'd1;
                    if (r_hcount == wsdf_pkg::KEY_LAST) begin
                        n_hcount     = 3'd0;
                        hdr_complete = 1'b1;
                    end
                end
                PH_DATA: begin
                    n_midx                = r_midx + 2'd1;
                    n_len                 = r_len - {{(LB-1){1'b0}}, 1'b1};
                    o_res_valid           = 1'b1;
                    o_res.payload_byte    = i_byte ^ key_byte;
                    o_res.frame_opcode    = r_opcode;
                    if (r_len == {{(LB-1){1'b0}}, 1'b1}) begin
                        o_res.last_byte = 1'b1;
                        n_phase         = PH_HDR0;
                    end
                end
                default: begin
                    // First header byte; unused phase codes land here too.
                    n_opcode  = i_byte[3:0] & wsdf_pkg::OPCODE_MASK[3:0];
                    n_key     = '0;
                    n_mask_en = 1'b0;
                    n_midx    = 2'd0;
                    n_hcount  = 3'd0;
                    n_len     = '0;
                    n_phase   = PH_HDR1;
                end
            endcase

            // Length known: read the key next, or finish the header.
            if (len_complete) begin
                n_hcount = 3'd0;
                if (n_mask_en) begin
                    n_phase = PH_KEY;
                end else begin
                    hdr_complete = 1'b1;
                end
            end

            // Header finished: a zero length gives the empty marker at once.
            if (hdr_complete) begin
                if (n_len == '0) begin
                    o_res_valid        = 1'b1;
                    o_res.payload_byte = 8'd0;
                    o_res.frame_opcode = r_opcode;
                    o_res.last_byte    = 1'b1;
                    o_res.empty_frame  = 1'b1;
                    n_phase            = PH_HDR0;
                end else begin
                    n_midx  = 2'd0;
                    n_phase = PH_DATA;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HDR0;
            r_hcount  <= 3'd0;
            r_len     <= '0;
            r_mask_en <= 1'b0;
            r_key     <= '0;
            r_midx    <= 2'd0;
            r_opcode  <= 4'd0;
        end else begin
            r_phase   <= n_phase;
            r_hcount  <= n_hcount;
            r_len     <= n_len;
            r_mask_en <= n_mask_en;
            r_key     <= n_key;
            r_midx    <= n_midx;
            r_opcode  <= n_opcode;
        end
    end

endmodule

`default_nettype wire

[rtl/wsdf_out_reg.sv]
`timescale 1ns / 1ps
`default_nettype none

module wsdf_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire wsdf_pkg::t_result i_res,
    output logic                   o_advance,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output wsdf_pkg::t_result      o_res
);

    logic              r_valid;
    wsdf_pkg::t_result r_res;

    // The pipeline moves whenever the held result is gone or is taken now.
    assign o_advance = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

[rtl/websocket_frame_deframer_top.sv]
// WebSocket receive deframer. The slave stream carries the received frame
// stream, one byte per beat in s_axis_tdata[7:0]. The master stream carries
// one beat per payload byte, already unmasked, with the frame opcode beside
// it; tlast marks the final payload byte of a frame. A frame of zero length
// gives a single marker beat with a zero payload byte, tlast high and
// tuser high, on the byte that completes its header. Header, extension and
// key bytes give no beat.
// Throughput is one byte per cycle while the receiver keeps tready high. A
// byte waits in the input register, and the header state is updated as it
// leaves; its result is shown on the master side on the next cycle. The
// input and result registers form a two-stage pipeline: while the receiver
// holds tready low, the pipeline fills and then s_axis_tready drops until
// the result is taken.
// Reset (synchronous, active low) empties both stages and returns the parser
// to wait for the first header byte of a new frame.
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer_top #(
    parameter int LENGTH_BITS = wsdf_pkg::LENGTH_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // [7:0] in_byte
    input  wire logic [wsdf_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // [7:0] payload_byte, [11:8] frame_opcode, [15:12] zero
    output logic [wsdf_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,
    output logic                                  o_m_axis_tlast,
    // [0] empty_frame
    output logic                                  o_m_axis_tuser
);

    logic              advance;
    logic              in_valid;
    logic [7:0]        in_byte;
    logic              res_valid;
    wsdf_pkg::t_result res;
    wsdf_pkg::t_result out_res;

    // Input register.
    wsdf_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_byte    (i_s_axis_tdata[7:0]),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_byte    (in_byte)
    );

    // Header state machine and unmasking.
    wsdf_parser #(
        .LB (LENGTH_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .i_byte      (in_byte),
        .i_advance   (advance),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register.
    wsdf_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (res_valid),
        .i_res     (res),
        .o_advance (advance),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_res     (out_res)
    );

    assign o_m_axis_tdata = {4'd0, out_res.frame_opcode, out_res.payload_byte};
    assign o_m_axis_tlast = out_res.last_byte;
    assign o_m_axis_tuser = out_res.empty_frame;

endmodule

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps

module tb;

    localparam int LEN_W = wsdf_pkg::LENGTH_BITS;

    // Length encodings used by the frame builder.
    localparam int FORM_LEN7  = 0;
    localparam int FORM_EXT16 = 1;
    localparam int FORM_EXT64 = 2;

    // Parser phases of the local copy of the deframer.
    typedef enum logic [2:0] {
        PARSE_HDR0  = 3'd0,
        PARSE_HDR1  = 3'd1,
        PARSE_EXT16 = 3'd2,
        PARSE_EXT64 = 3'd3,
        PARSE_KEY   = 3'd4,
        PARSE_DATA  = 3'd5
    } t_parse_phase;

    // One stream byte waiting to be sent, with its idle gap and drain flag.
    typedef struct {
        logic [7:0] data;
        int         gap;
        bit         drain;
    } t_stream_item;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata = 8'd0;
    logic       s_tready;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    t_stream_item        pending_bytes[$];
    wsdf_pkg::t_result   payload_beats_due[$];

    // Local parser state, reset values as after reset of the block.
    t_parse_phase     rx_phase = PARSE_HDR0;
    logic [2:0]       hdr_cnt = 3'd0;
    logic [LEN_W-1:0] bytes_left = '0;
    logic             masked_frame = 1'b0;
    logic [31:0]      key_word = 32'd0;
    logic [1:0]       key_idx = 2'd0;
    logic [3:0]       opcode_now = 4'd0;

    int  src_wait = 0;
    int  sink_wait = 0;
    bit  src_calm = 1'b0;
    bit  sink_calm = 1'b0;
    int  failures = 0;
    int  beats_checked = 0;
    int  bytes_accepted = 0;
    int  bytes_queued = 0;
    int  frames_built = 0;
    int  empty_built = 0;

    websocket_frame_deframer_top u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .o_m_axis_tuser  (m_tuser)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The header is complete: either emit the empty marker or start payload.
    function void header_complete();
        if (bytes_left == '0) begin
            payload_beats_due.push_back('{payload_byte: 8'd0, frame_opcode: opcode_now,
                                          last_byte: 1'b1, empty_frame: 1'b1});
            rx_phase = PARSE_HDR0;
        end else begin
            key_idx = 2'd0;
            rx_phase = PARSE_DATA;
        end
    endfunction

    // The length is known; a masked frame still has its key to read.
    function void length_complete();
        hdr_cnt = 3'd0;
        if (masked_frame)
            rx_phase = PARSE_KEY;
        else
            header_complete();
    endfunction

    // Advance the local parser by one accepted stream byte.
    function void deframe_byte(input logic [7:0] b);
        logic [6:0] len7;
        logic [7:0] key_byte;
        logic [7:0] plain;
        case (rx_phase)
            PARSE_HDR1: begin
                masked_frame = (b & wsdf_pkg::MASK_FLAG) != 8'd0;
                len7 = 7'(b & wsdf_pkg::LEN7_MASK);
                hdr_cnt = 3'd0;
                bytes_left = '0;
                if (len7 == wsdf_pkg::LEN_EXT16) begin
                    rx_phase = PARSE_EXT16;
                end else if (len7 == wsdf_pkg::LEN_EXT64) begin
                    rx_phase = PARSE_EXT64;
                end else begin
                    bytes_left = LEN_W'(len7);
                    length_complete();
                end
            end
            PARSE_EXT16: begin
                bytes_left = {bytes_left[LEN_W-9:0], b};
                if (hdr_cnt == wsdf_pkg::EXT16_LAST)
                    length_complete();
                else
                    hdr_cnt = hdr_cnt + 3'd1;
            end
            PARSE_EXT64: begin
                bytes_left = {bytes_left[LEN_W-9:0], b};
                if (hdr_cnt == wsdf_pkg::EXT64_LAST)
                    length_complete();
                else
                    hdr_cnt = hdr_cnt + 3'd1;
            end
            PARSE_KEY: begin
                key_word = {key_word[23:0], b};
                if (hdr_cnt == wsdf_pkg::KEY_LAST) begin
                    hdr_cnt = 3'd0;
                    header_complete();
                end else begin
                    hdr_cnt = hdr_cnt + 3'd1;
                end
            end
            PARSE_DATA: begin
                key_byte = 8'(key_word >> (8 * (3 - int'(key_idx))));
                plain = b ^ key_byte;
                key_idx = key_idx + 2'd1;
                bytes_left = bytes_left - LEN_W'(1);
                payload_beats_due.push_back('{payload_byte: plain, frame_opcode: opcode_now,
                                              last_byte: bytes_left == '0, empty_frame: 1'b0});
                if (bytes_left == '0)
                    rx_phase = PARSE_HDR0;
            end
            default: begin
                opcode_now = 4'(b & wsdf_pkg::OPCODE_MASK);
                key_word = 32'd0;
                masked_frame = 1'b0;
                key_idx = 2'd0;
                hdr_cnt = 3'd0;
                bytes_left = '0;
                rx_phase = PARSE_HDR1;
            end
        endcase
    endfunction

    task automatic queue_byte(input logic [7:0] b, input bit drain);
        pending_bytes.push_back('{data: b, gap: src_calm ? 0 : $urandom_range(0, 7),
                                  drain: drain});
        bytes_queued++;
    endtask

    // Build one frame: header, length extension, optional key and payload.
    // A negative fill gives random payload bytes.
    task automatic queue_frame(input logic [7:0] hdr0, input bit masked, input logic [31:0] len,
                               input int form, input logic [31:0] high_len,
                               input logic [31:0] key, input int fill, input bit drain);
        queue_byte(hdr0, drain);
        if (form == FORM_EXT16) begin
            queue_byte({masked, wsdf_pkg::LEN_EXT16}, 1'b0);
            queue_byte(len[15:8], 1'b0);
            queue_byte(len[7:0], 1'b0);
        end else if (form == FORM_EXT64) begin
            queue_byte({masked, wsdf_pkg::LEN_EXT64}, 1'b0);
            for (int i = 3; i >= 0; i--)
                queue_byte(high_len[8*i +: 8], 1'b0);
            for (int i = 3; i >= 0; i--)
                queue_byte(len[8*i +: 8], 1'b0);
        end else begin
            queue_byte({masked, len[6:0]}, 1'b0);
        end
        if (masked) begin
            for (int i = 3; i >= 0; i--)
                queue_byte(key[8*i +: 8], 1'b0);
        end
        for (int i = 0; i < int'(len); i++)
            queue_byte(fill < 0 ? 8'($urandom) : 8'(fill), 1'b0);
        frames_built++;
        if (len == 32'd0)
            empty_built++;
    endtask

    // Sender: present queued bytes with their drawn gaps, predict each accepted beat.
    always @(posedge clk) begin
        logic took;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            src_wait <= 0;
        end else begin
            took = s_tvalid && s_tready;
            if (took) begin
                deframe_byte(s_tdata);
                bytes_accepted++;
            end
            if (s_tvalid && !took) begin
                // Hold the current beat until it is taken.
            end else if (pending_bytes.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (pending_bytes[0].drain && payload_beats_due.size() != 0) begin
                s_tvalid <= 1'b0;
            end else if (src_wait < pending_bytes[0].gap) begin
                s_tvalid <= 1'b0;
                src_wait <= src_wait + 1;
            end else begin
                s_tdata <= pending_bytes[0].data;
                s_tvalid <= 1'b1;
                src_wait <= 0;
                void'(pending_bytes.pop_front());
            end
        end
    end

    // Receiver: check each accepted beat against the oldest prediction, then stall a while.
    always @(posedge clk) begin
        wsdf_pkg::t_result want;
        logic [15:0]       want_data;
        int                hold;
        if (!rst_n) begin
            m_tready <= 1'b0;
            sink_wait <= 0;
        end else if (m_tvalid && m_tready) begin
            if (payload_beats_due.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected beat: data %h last %b user %b",
                             m_tdata, m_tlast, m_tuser);
            end else begin
                want = payload_beats_due.pop_front();
                want_data = {4'd0, want.frame_opcode, want.payload_byte};
                beats_checked++;
                if (m_tdata !== want_data || m_tlast !== want.last_byte
                        || m_tuser !== want.empty_frame) begin
                    failures++;
                    if (failures <= 10)
                        $display({"beat %0d mismatch: expected byte %h opcode %h last %b ",
                                  "empty %b, got byte %h opcode %h pad %h last %b empty %b"},
                                 beats_checked, want.payload_byte, want.frame_opcode,
                                 want.last_byte, want.empty_frame, m_tdata[7:0],
                                 m_tdata[11:8], m_tdata[15:12], m_tlast, m_tuser);
                end
            end
            hold = sink_calm ? 0 : $urandom_range(0, 7);
            if ($urandom_range(0, 99) == 0)
                sink_calm <= !sink_calm;
            sink_wait <= hold;
            m_tready <= (hold == 0);
        end else if (sink_wait > 0) begin
            sink_wait <= sink_wait - 1;
            m_tready <= (sink_wait == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Stimulus, reset and the end of the run.
    initial begin
        int          pick;
        int          form;
        int          directed_end;
        bit          masked;
        bit          drain;
        bit          mid_drain_done;
        logic [31:0] len;

        // Empty frames: the marker comes on the length byte, the last key byte,
        // the last 16-bit extension byte and the last key byte after a 64-bit extension.
        queue_frame(8'hF1, 1'b0, 32'd0, FORM_LEN7, 32'd0, 32'd0, -1, 1'b0);
        queue_frame(8'h0F, 1'b1, 32'd0, FORM_LEN7, 32'd0, 32'hFFFF_FFFF, -1, 1'b0);
        queue_frame(8'h80, 1'b0, 32'd0, FORM_EXT16, 32'd0, 32'd0, -1, 1'b0);
        queue_frame(8'h8A, 1'b1, 32'd0, FORM_EXT64, 32'hFFFF_FFFF, 32'h1234_5678, -1, 1'b0);
        // All-ones key over zero bytes, and an unmasked frame passing 0xFF through.
        queue_frame(8'h02, 1'b1, 32'd1, FORM_LEN7, 32'd0, 32'hFFFF_FFFF, 8'h00, 1'b0);
        queue_frame(8'h79, 1'b0, 32'd3, FORM_LEN7, 32'd0, 32'hA5A5_A5A5, 8'hFF, 1'b0);
        // A non-minimal 16-bit length with a key that wraps past four bytes.
        queue_frame(8'h01, 1'b1, 32'd6, FORM_EXT16, 32'd0, 32'h0102_8040, -1, 1'b0);
        // The upper half of a 64-bit length is dropped.
        queue_frame(8'h02, 1'b0, 32'd2, FORM_EXT64, 32'hDEAD_BEEF, 32'd0, -1, 1'b0);
        directed_end = bytes_queued;

        // Random frames, mostly short, with the sender pausing for a full drain twice.
        mid_drain_done = 1'b0;
        while (bytes_queued < directed_end + 1200) begin
            pick = $urandom_range(0, 99);
            masked = 1'($urandom_range(0, 1));
            if (pick < 60) begin
                form = FORM_LEN7;
                len = $urandom_range(0, 12);
            end else if (pick < 75) begin
                form = FORM_LEN7;
                len = $urandom_range(13, 125);
            end else if (pick < 90) begin
                form = FORM_EXT16;
                len = $urandom_range(0, 300);
            end else begin
                form = FORM_EXT64;
                len = $urandom_range(0, 40);
            end
            drain = (bytes_queued == directed_end);
            if (!mid_drain_done && bytes_queued > directed_end + 600) begin
                drain = 1'b1;
                mid_drain_done = 1'b1;
            end
            src_calm = ($urandom_range(0, 3) == 0);
            queue_frame(8'($urandom), masked, len, form, $urandom, $urandom, -1, drain);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || s_tvalid || payload_beats_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        failures += payload_beats_due.size();

        $display("Sent %0d frames (%0d of zero length) as %0d stream bytes.",
                 frames_built, empty_built, bytes_accepted);
        $display("Checked %0d output beats, %0d failures.", beats_checked, failures);
        if (failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog for a stuck handshake.
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
